[hw/rtl/tpv_pkg.sv]
// Package for the three-axis PID velocity unit: data formats, widths,
// register indexes, saturation limits and the gain bundle. No dependencies.
package tpv_pkg;

  localparam int DATA_WIDTH     = 16;
  localparam int INTEGRAL_WIDTH = 32;
  localparam int FRAC_BITS      = 8;
  localparam int SEQ_WIDTH      = 32;
  localparam int CFG_INDEX_W    = 8;

  // Exact sum of the three products: the widest product plus two guard bits.
  localparam int SUM_W = DATA_WIDTH + INTEGRAL_WIDTH + 2;

  typedef logic signed [DATA_WIDTH-1:0]     data_t;
  typedef logic signed [DATA_WIDTH:0]       diff_t;
  typedef logic signed [INTEGRAL_WIDTH-1:0] integ_t;
  typedef logic signed [SUM_W-1:0]          sum_t;
  typedef logic        [SEQ_WIDTH-1:0]      seq_t;
  typedef logic        [CFG_INDEX_W-1:0]    cfg_index_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GAIN_P        = CFG_INDEX_W'(0),
    REG_GAIN_I        = CFG_INDEX_W'(1),
    REG_GAIN_D        = CFG_INDEX_W'(2),
    REG_ALT_THRESHOLD = CFG_INDEX_W'(3)
  } cfg_reg_e;

  typedef struct packed {
    data_t p;
    data_t i;
    data_t d;
  } gains_t;

  // Reset values: unity proportional gain, threshold 0.1 in Q8.8.
  localparam data_t GAIN_P_RESET        = data_t'(DATA_WIDTH'(1) << FRAC_BITS);
  localparam data_t GAIN_I_RESET        = '0;
  localparam data_t GAIN_D_RESET        = '0;
  localparam data_t ALT_THRESHOLD_RESET = data_t'(DATA_WIDTH'(26));

  localparam integ_t INTEG_MAX = integ_t'({1'b0, {(INTEGRAL_WIDTH-1){1'b1}}});
  localparam integ_t INTEG_MIN = integ_t'({1'b1, {(INTEGRAL_WIDTH-1){1'b0}}});

  localparam sum_t ROUND_BIAS = sum_t'(SUM_W'(1) << (FRAC_BITS - 1));
  localparam sum_t DATA_MAX   = sum_t'({{(SUM_W-DATA_WIDTH+1){1'b0}},
                                        {(DATA_WIDTH-1){1'b1}}});
  localparam sum_t DATA_MIN   = ~DATA_MAX;

endpackage

[hw/rtl/tpv_if.sv]
// Handshake channels of the three-axis PID velocity unit: input item,
// result item and configuration write. Depends on tpv_pkg.
interface tpv_in_if import tpv_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t err_x;
  data_t err_y;
  data_t err_z;
  data_t altitude;

  modport source (output valid, err_x, err_y, err_z, altitude, input ready);
  modport sink   (input valid, err_x, err_y, err_z, altitude, output ready);
endinterface

interface tpv_out_if import tpv_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t vel_x;
  data_t vel_y;
  data_t vel_z;
  seq_t  sequence_res;

  modport source (output valid, vel_x, vel_y, vel_z, sequence_res, input ready);
  modport sink   (input valid, vel_x, vel_y, vel_z, sequence_res, output ready);
endinterface

interface tpv_cfg_if import tpv_pkg::*; ();
  logic       valid;
  logic       ready;
  cfg_index_t index;
  data_t      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/tpv_axis.sv]
// One axis of the PID: integral and previous-error state, the registered
// terms of the current beat, and the gain products with rounding. Uses tpv_pkg.
module tpv_axis import tpv_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   step_i,
  input  logic   integrate_i,
  input  data_t  err_i,
  input  gains_t gains_i,
  output data_t  vel_o
);

  integ_t integ_q, integ_d;
  data_t  prev_q;
  data_t  e_q;
  integ_t i_q;
  diff_t  d_q;

  logic signed [INTEGRAL_WIDTH:0] acc;
  diff_t diff;

  logic signed [2*DATA_WIDTH-1:0]            prod_p;
  logic signed [DATA_WIDTH+INTEGRAL_WIDTH-1:0] prod_i;
  logic signed [2*DATA_WIDTH:0]              prod_d;
  sum_t sum, scaled;

  // Saturating integral update; the output uses the updated sum.
  always_comb begin
    acc     = (INTEGRAL_WIDTH+1)'(integ_q) + (INTEGRAL_WIDTH+1)'(err_i);
    integ_d = integ_q;
    if (integrate_i) begin
      if (acc[INTEGRAL_WIDTH] != acc[INTEGRAL_WIDTH-1]) begin
        integ_d = acc[INTEGRAL_WIDTH] ? INTEG_MIN : INTEG_MAX;
      end else begin
        integ_d = acc[INTEGRAL_WIDTH-1:0];
      end
    end
    diff = diff_t'(err_i) - diff_t'(prev_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      prev_q  <= '0;
    end else if (step_i) begin
      integ_q <= integ_d;
      prev_q  <= err_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      e_q <= err_i;
      i_q <= integ_d;
      d_q <= diff;
    end
  end

  // Products carry 2*FRAC_BITS fraction bits; round half up, then saturate.
  always_comb begin
    prod_p = gains_i.p * e_q;
    prod_i = gains_i.i * i_q;
    prod_d = gains_i.d * d_q;
    sum    = sum_t'(prod_p) + sum_t'(prod_i) + sum_t'(prod_d);
    scaled = (sum + ROUND_BIAS) >>> FRAC_BITS;
    if (scaled > DATA_MAX) begin
      vel_o = DATA_MAX[DATA_WIDTH-1:0];
    end else if (scaled < DATA_MIN) begin
      vel_o = DATA_MIN[DATA_WIDTH-1:0];
    end else begin
      vel_o = scaled[DATA_WIDTH-1:0];
    end
  end

endmodule

[hw/rtl/three_axis_pid_velocity_unit.sv]
// Three-axis PID velocity unit: takes a position error per axis and the
// altitude in signed Q8.8 and returns one saturated velocity command per beat,
// tagged with a wrapping sequence number starting at zero. It accepts one beat
// per clock unless output back-pressure stalls it; a result passes the term
// register, then the output register; the integral and previous-error state
// is updated per accepted beat, which allows that rate. Integration runs only
// while the altitude is strictly above the configured threshold. Configuration
// writes are always accepted; indexes beyond the four registers are ignored.
// Depends on tpv_pkg, tpv_if and tpv_axis.
module three_axis_pid_velocity_unit import tpv_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  tpv_in_if.sink    in_i,
  tpv_cfg_if.sink   cfg_i,
  tpv_out_if.source out_o
);

  gains_t gains_q;
  data_t  thresh_q;
  seq_t   seq_cnt_q;
  seq_t   term_seq_q;
  logic   term_valid_q;
  logic   out_valid_q;
  data_t  vel_x_q, vel_y_q, vel_z_q;
  seq_t   out_seq_q;

  logic  in_fire, cfg_fire, term_adv, out_adv, integrate;
  data_t vel_x, vel_y, vel_z;

  assign out_adv   = !out_valid_q || out_o.ready;
  assign term_adv  = !term_valid_q || out_adv;
  assign in_i.ready  = term_adv;
  assign cfg_i.ready = 1'b1;
  assign in_fire   = in_i.valid && term_adv;
  assign cfg_fire  = cfg_i.valid;
  assign integrate = in_i.altitude > thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q.p <= GAIN_P_RESET;
      gains_q.i <= GAIN_I_RESET;
      gains_q.d <= GAIN_D_RESET;
      thresh_q  <= ALT_THRESHOLD_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        REG_GAIN_P:        gains_q.p <= cfg_i.data;
        REG_GAIN_I:        gains_q.i <= cfg_i.data;
        REG_GAIN_D:        gains_q.d <= cfg_i.data;
        REG_ALT_THRESHOLD: thresh_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  tpv_axis u_axis_x (
    .clk_i, .rst_ni, .step_i(in_fire), .integrate_i(integrate),
    .err_i(in_i.err_x), .gains_i(gains_q), .vel_o(vel_x)
  );
  tpv_axis u_axis_y (
    .clk_i, .rst_ni, .step_i(in_fire), .integrate_i(integrate),
    .err_i(in_i.err_y), .gains_i(gains_q), .vel_o(vel_y)
  );
  tpv_axis u_axis_z (
    .clk_i, .rst_ni, .step_i(in_fire), .integrate_i(integrate),
    .err_i(in_i.err_z), .gains_i(gains_q), .vel_o(vel_z)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_cnt_q    <= '0;
      term_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (in_fire) begin
        seq_cnt_q <= seq_cnt_q + 1'b1;
      end
      if (term_adv) begin
        term_valid_q <= in_fire;
      end
      if (out_adv) begin
        out_valid_q <= term_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      term_seq_q <= seq_cnt_q;
    end
    if (out_adv && term_valid_q) begin
      vel_x_q   <= vel_x;
      vel_y_q   <= vel_y;
      vel_z_q   <= vel_z;
      out_seq_q <= term_seq_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.vel_x        = vel_x_q;
  assign out_o.vel_y        = vel_y_q;
  assign out_o.vel_z        = vel_z_q;
  assign out_o.sequence_res = out_seq_q;

  // The sequence counter moves by exactly one per accepted beat.
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> seq_cnt_q == $past(seq_cnt_q) + 1'b1)
    else $error("sequence counter did not advance on an accepted beat");

  // A held term stage must block the input.
  a_term_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (term_valid_q && !out_adv) |-> !in_fire)
    else $error("input accepted while the term stage was held");

  // A result can only appear from a loaded term stage.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(term_valid_q))
    else $error("result valid without a term stage beat");

endmodule
